/* sv/crdg_pkg.sv */
// shared constants and helpers for the camera ray direction generator
package crdg_pkg;

  localparam int MAX_RES_DEF = 4096;

  localparam logic [2:0] REG_RES_X  = 3'd0;
  localparam logic [2:0] REG_RES_Y  = 3'd1;
  localparam logic [2:0] REG_ASPECT = 3'd2;
  localparam logic [2:0] REG_FOV    = 3'd3;
  localparam logic [2:0] REG_QW     = 3'd4;
  localparam logic [2:0] REG_QX     = 3'd5;
  localparam logic [2:0] REG_QY     = 3'd6;
  localparam logic [2:0] REG_QZ     = 3'd7;

  localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAT_MIN = -24'sh800000;

  // saturate a wide signed value to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = SAT_MAX;
    end else if (v < -64'sd8388608) begin
      r = SAT_MIN;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* sv/camera_ray_direction_gen.sv */
// Pinhole camera ray direction generator with tent-filtered jitter. One word is
// taken every cycle while the output is taken, and its direction is built in 17 sqrt
// stages plus 30 divide stages plus eight arithmetic stages; the whole path is a
// pipeline that stalls as one when the output is not taken.
// The jitter square root is a restoring root with one result bit per stage (17
// stages), and the divide by the resolution is a restoring divider with one
// quotient bit per stage (30 stages). Configuration must be written while idle.
module camera_ray_direction_gen #(
  parameter int MAX_RES = crdg_pkg::MAX_RES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        pixel_x,
  input  logic [11:0]        pixel_y,
  input  logic [15:0]        rand_a,
  input  logic [15:0]        rand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] dir_x,
  output logic signed [23:0] dir_y,
  output logic signed [23:0] dir_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int RW = $clog2(MAX_RES + 1);
  localparam int SQN = 17;           // root bits
  localparam int DQN = 30;           // quotient bits (|num| < 2^30)
  localparam int NST = SQN + DQN + 8;

  // configuration registers
  logic [12:0] res_x, res_y;
  logic [23:0] aspect_ratio, fov_scale;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_x <= 13'd640;
      res_y <= 13'd480;
      aspect_ratio <= 24'd87381;
      fov_scale <= 24'd65536;
      quat_w <= 16'sd16384;
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        crdg_pkg::REG_RES_X:  res_x <= cfg_data[12:0];
        crdg_pkg::REG_RES_Y:  res_y <= cfg_data[12:0];
        crdg_pkg::REG_ASPECT: aspect_ratio <= cfg_data;
        crdg_pkg::REG_FOV:    fov_scale <= cfg_data;
        crdg_pkg::REG_QW:     quat_w <= cfg_data[15:0];
        crdg_pkg::REG_QX:     quat_x <= cfg_data[15:0];
        crdg_pkg::REG_QY:     quat_y <= cfg_data[15:0];
        crdg_pkg::REG_QZ:     quat_z <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // effective resolution: zero as one, clamp to MAX_RES
  logic [RW-1:0] erx, ery;
  always_comb begin
    if (res_x == '0) erx = RW'(1);
    else if (32'(res_x) > MAX_RES) erx = RW'(MAX_RES);
    else erx = RW'(res_x);
    if (res_y == '0) ery = RW'(1);
    else if (32'(res_y) > MAX_RES) ery = RW'(MAX_RES);
    else ery = RW'(res_y);
  end

  // pipeline advance: whole pipe moves when output slot is free
  logic adv;
  logic [NST-1:0] vld;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], in_valid};
  end

  // ---------------- square root stages ----------------
  // radicand = s<<16 or (2^17-s)<<16, at most 2^32 ; root up to 2^16
  typedef struct packed {
    logic [11:0] px, py;
    logic [34:0] rema, remb;   // remaining radicand
    logic [16:0] roota, rootb;
    logic        hia, hib;     // upper branch of tent
  } sq_t;

  sq_t sq [SQN+1];

  always_comb begin
    logic [16:0] sa, sb;
    sa = {rand_a, 1'b0};
    sb = {rand_b, 1'b0};
    sq[0].px = pixel_x;
    sq[0].py = pixel_y;
    sq[0].hia = sa[16];
    sq[0].hib = sb[16];
    sq[0].rema = sa[16] ? {(17'h10000 - {1'b0, sa[15:0]}), 16'h0, 2'b0} >> 2
                        : {2'b0, sa, 16'h0};
    sq[0].remb = sb[16] ? {(17'h10000 - {1'b0, sb[15:0]}), 16'h0, 2'b0} >> 2
                        : {2'b0, sb, 16'h0};
    sq[0].roota = '0;
    sq[0].rootb = '0;
  end

  // bit-by-bit root: one result bit per stage, from bit 16 down
  function automatic void sqstep(input logic [34:0] rem, input logic [16:0] root,
                                 input int k, output logic [34:0] rem_o,
                                 output logic [16:0] root_o);
    logic [35:0] trial;
    trial = (36'(root) << (k + 1)) + (36'd1 << (2 * k));
    if (36'(rem) >= trial) begin
      rem_o = 35'(36'(rem) - trial);
      root_o = root | (17'd1 << k);
    end else begin
      rem_o = rem;
      root_o = root;
    end
  endfunction

  for (genvar g = 0; g < SQN; g++) begin : g_sq
    sq_t nx;
    always_comb begin
      nx = sq[g];
      sqstep(sq[g].rema, sq[g].roota, SQN - 1 - g, nx.rema, nx.roota);
      sqstep(sq[g].remb, sq[g].rootb, SQN - 1 - g, nx.remb, nx.rootb);
    end
    always_ff @(posedge clk) begin
      if (adv) sq[g+1] <= nx;
    end
  end

  // numerator: res*32768 - pix*65536 + jitter
  typedef struct packed {
    logic        nx_neg, ny_neg;
    logic [30:0] remx, remy;    // partial remainder
    logic [29:0] qx, qy;        // magnitude being shifted out / quotient
  } dv_t;

  dv_t dv [DQN+1];

  always_comb begin
    logic signed [31:0] jx, jy, nx, ny;
    jx = sq[SQN].hia ? 32'sd65536 - 32'($signed({1'b0, sq[SQN].roota}))
                     : 32'($signed({1'b0, sq[SQN].roota})) - 32'sd65536;
    jy = sq[SQN].hib ? 32'sd65536 - 32'($signed({1'b0, sq[SQN].rootb}))
                     : 32'($signed({1'b0, sq[SQN].rootb})) - 32'sd65536;
    nx = 32'($signed({1'b0, erx})) * 32'sd32768
         - 32'($signed({1'b0, sq[SQN].px})) * 32'sd65536 + jx;
    ny = 32'($signed({1'b0, ery})) * 32'sd32768
         - 32'($signed({1'b0, sq[SQN].py})) * 32'sd65536 + jy;
    dv[0].nx_neg = nx[31];
    dv[0].ny_neg = ny[31];
    dv[0].qx = nx[31] ? 30'(-nx) : 30'(nx);
    dv[0].qy = ny[31] ? 30'(-ny) : 30'(ny);
    dv[0].remx = '0;
    dv[0].remy = '0;
  end

  // restoring divide, one quotient bit per stage
  for (genvar g = 0; g < DQN; g++) begin : g_dv
    dv_t nx;
    logic [31:0] tx, ty;
    always_comb begin
      nx = dv[g];
      tx = {dv[g].remx, dv[g].qx[29]};
      ty = {dv[g].remy, dv[g].qy[29]};
      if (tx >= 32'(erx)) begin
        nx.remx = 31'(tx - 32'(erx));
        nx.qx = {dv[g].qx[28:0], 1'b1};
      end else begin
        nx.remx = 31'(tx);
        nx.qx = {dv[g].qx[28:0], 1'b0};
      end
      if (ty >= 32'(ery)) begin
        nx.remy = 31'(ty - 32'(ery));
        nx.qy = {dv[g].qy[28:0], 1'b1};
      end else begin
        nx.remy = 31'(ty);
        nx.qy = {dv[g].qy[28:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) dv[g+1] <= nx;
    end
  end

  // ---------------- scale stages ----------------
  logic signed [30:0] sx, sy;
  assign sx = dv[DQN].nx_neg ? -$signed({1'b0, dv[DQN].qx}) : $signed({1'b0, dv[DQN].qx});
  assign sy = dv[DQN].ny_neg ? -$signed({1'b0, dv[DQN].qy}) : $signed({1'b0, dv[DQN].qy});

  // stage a: sx*aspect, sy*fov (>>> is a floor shift)
  logic signed [55:0] pa_x, pa_y;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_x <= 56'(sx) * $signed({32'd0, aspect_ratio});
      pa_y <= 56'(sy) * $signed({32'd0, fov_scale});
    end
  end

  // stage b: (vx>>16)*fov, saturate vy
  logic signed [63:0] pb_x;
  logic signed [23:0] vy_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      pb_x <= 64'(pa_x >>> 16) * $signed({40'd0, fov_scale});
      vy_b <= crdg_pkg::sat24(64'(pa_y >>> 16));
    end
  end

  // stage c: saturate vx
  logic signed [23:0] vx_c, vy_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      vx_c <= crdg_pkg::sat24(pb_x >>> 16);
      vy_c <= vy_b;
    end
  end

  // stage d: products q * v, vz = 65536 is a shift
  logic signed [39:0] m_xx, m_xy, m_yx, m_yy, m_zx, m_zy, m_wx, m_wy;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_wx <= 40'(quat_w) * 40'(vx_c);
      m_wy <= 40'(quat_w) * 40'(vy_c);
      m_xx <= 40'(quat_x) * 40'(vx_c);
      m_xy <= 40'(quat_x) * 40'(vy_c);
      m_yx <= 40'(quat_y) * 40'(vx_c);
      m_yy <= 40'(quat_y) * 40'(vy_c);
      m_zx <= 40'(quat_z) * 40'(vx_c);
      m_zy <= 40'(quat_z) * 40'(vy_c);
    end
  end

  // stage e: t = q * (0, v), Q.30
  logic signed [41:0] t_w, t_x, t_y, t_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      t_w <= -42'(m_xx) - 42'(m_yy) - (42'(quat_z) <<< 16);
      t_x <= 42'(m_wx) + (42'(quat_y) <<< 16) - 42'(m_zy);
      t_y <= 42'(m_wy) - (42'(quat_x) <<< 16) + 42'(m_zx);
      t_z <= (42'(quat_w) <<< 16) + 42'(m_xy) - 42'(m_yx);
    end
  end

  // stage f: twelve products t*q (42x16)
  logic signed [57:0] p [12];
  always_ff @(posedge clk) begin
    if (adv) begin
      p[0]  <= 58'(t_w) * 58'(quat_x);
      p[1]  <= 58'(t_x) * 58'(quat_w);
      p[2]  <= 58'(t_y) * 58'(quat_z);
      p[3]  <= 58'(t_z) * 58'(quat_y);
      p[4]  <= 58'(t_w) * 58'(quat_y);
      p[5]  <= 58'(t_x) * 58'(quat_z);
      p[6]  <= 58'(t_y) * 58'(quat_w);
      p[7]  <= 58'(t_z) * 58'(quat_x);
      p[8]  <= 58'(t_w) * 58'(quat_z);
      p[9]  <= 58'(t_x) * 58'(quat_y);
      p[10] <= 58'(t_y) * 58'(quat_x);
      p[11] <= 58'(t_z) * 58'(quat_w);
    end
  end

  // stage g: sums, Q.44
  logic signed [59:0] r_x, r_y, r_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      r_x <= -60'(p[0]) + 60'(p[1]) - 60'(p[2]) + 60'(p[3]);
      r_y <= -60'(p[4]) + 60'(p[5]) + 60'(p[6]) - 60'(p[7]);
      r_z <= -60'(p[8]) - 60'(p[9]) + 60'(p[10]) + 60'(p[11]);
    end
  end

  // stage h: reduce and saturate into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x <= crdg_pkg::sat24(64'(r_x >>> 28));
      dir_y <= crdg_pkg::sat24(64'(r_y >>> 28));
      dir_z <= crdg_pkg::sat24(64'(r_z >>> 28));
    end
  end

  // output valid, dir_x and dir_z hold while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dir_x) && $stable(dir_z))
    else $error("stalled output word changed");

  // an accepted input shows up in the first stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost at pipe entry");

  // the pipe never moves while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(vld))
    else $error("pipe moved during stall");

endmodule
